### src/msam_pkg.sv
// Shared types and constants of the stereo mixing ring.
// No dependencies; imported by every module of the mixer.
package msam_pkg;

  localparam int RING_FRAMES_DEF  = 16384;
  localparam int STREAM_COUNT_DEF = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [18:0] ACC_MAX    = 19'sh3FFFF;
  localparam logic signed [18:0] ACC_MIN    = 19'sh40000;
  localparam logic [14:0]        COUNT_MAX  = 15'h7FFF;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         sid;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } item_t;

  typedef struct packed {
    logic mixer_enable;
    logic sink_present;
  } cfg_t;

  typedef struct packed {
    logic signed [18:0] l;
    logic signed [18:0] r;
  } slot_t;

endpackage

### src/msam_front.sv
// Front end: takes input beats, maps out-of-range stream ids to stream 0
// and holds them in a two-entry queue for the engine. Uses msam_pkg.
module msam_front
  import msam_pkg::*;
#(
  parameter int STREAM_COUNT = STREAM_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clearing,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [3:0]         in_stream_id,
  input  logic signed [15:0] in_left_sample,
  input  logic signed [15:0] in_right_sample,
  input  logic               in_last_of_submit,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  item_t              ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               push;
  item_t              new_item;

  assign in_ready = !clearing && (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = ent_r[rd_ptr_r];

  always_comb begin
    new_item.cmd   = in_cmd;
    new_item.sid   = ({1'b0, in_stream_id} >= 5'(STREAM_COUNT)) ? 4'd0 : in_stream_id;
    new_item.left  = in_left_sample;
    new_item.right = in_right_sample;
    new_item.last  = in_last_of_submit;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

### src/msam_back.sv
// Engine: ring memory, stream cursors, read position and high water.
// Two phases per item (read, then write back), plus the result register.
// Uses msam_pkg; fed by msam_front.
module msam_back
  import msam_pkg::*;
#(
  parameter int RING_FRAMES  = RING_FRAMES_DEF,
  parameter int STREAM_COUNT = STREAM_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_right,
  output logic               out_frame_valid,
  output logic               out_accepted,
  output logic [14:0]        out_space,
  output logic [14:0]        out_buffered,
  output logic               out_eos
);

  localparam int IDX_W = (RING_FRAMES > 1) ? $clog2(RING_FRAMES) : 1;
  localparam int SID_W = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_FRAMES - 1);
  localparam logic [31:0]      RING_LEN = 32'(RING_FRAMES);

  localparam logic [1:0] PH_CLR = 2'd0;
  localparam logic [1:0] PH_RD  = 2'd1;
  localparam logic [1:0] PH_WR  = 2'd2;

  function automatic logic [IDX_W-1:0] next_idx(input logic [31:0] pos,
                                                 input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] n;
    if (pos == '1 || idx == LAST_IDX) n = '0;
    else n = idx + IDX_W'(1);
    return n;
  endfunction

  function automatic logic signed [18:0] acc_add(input logic signed [18:0] a,
                                                 input logic signed [15:0] b);
    logic signed [19:0] s;
    logic signed [18:0] res;
    s = 20'(a) + 20'(b);
    if (s > 20'(ACC_MAX)) res = ACC_MAX;
    else if (s < 20'(ACC_MIN)) res = ACC_MIN;
    else res = s[18:0];
    return res;
  endfunction

  function automatic logic signed [15:0] clamp16(input logic signed [18:0] v);
    logic signed [15:0] res;
    if (v > 19'(SAMPLE_MAX)) res = SAMPLE_MAX;
    else if (v < 19'(SAMPLE_MIN)) res = SAMPLE_MIN;
    else res = v[15:0];
    return res;
  endfunction

  function automatic logic [14:0] sat_count(input logic [31:0] v);
    return (|v[31:15]) ? COUNT_MAX : v[14:0];
  endfunction

  // control state
  logic [1:0]        phase_r, phase_nxt;
  logic [IDX_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [31:0]       rp_r, hw_r;
  logic [IDX_W-1:0]  rp_idx_r;
  logic [31:0]       cur_r [STREAM_COUNT];
  logic [IDX_W-1:0]  cur_idx_r [STREAM_COUNT];
  logic              out_valid_r, out_valid_nxt;

  // item held between the phases
  logic              op_mix_r, op_drain_r, cmd_r, last_r;
  logic [SID_W-1:0]  sid_r;
  logic [IDX_W-1:0]  addr_r;
  logic signed [15:0] left_r, right_r;
  slot_t             rdata_r;

  slot_t             ring_mem [RING_FRAMES];

  // result register
  logic signed [15:0] oleft_r, oright_r;
  logic              ofv_r, oacc_r, oeos_r;
  logic [14:0]       ospace_r, obuf_r;

  // read phase
  logic [SID_W-1:0]  sid_h;
  logic [31:0]       c_rd, eff, lead, eff_inc;
  logic [IDX_W-1:0]  cidx_rd, eff_idx, rd_addr;
  logic              behind, mix_go, drain_go, raise_hw, rd_fire;

  // write phase
  logic              out_free, wr_fire, mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  slot_t             mixed, mem_wdata;
  logic [31:0]       c_wr, dist2, free2;
  logic              behind2;
  logic [14:0]       space_now;

  assign clearing  = (phase_r == PH_CLR);
  assign out_free  = !out_valid_r || out_ready;
  assign rd_fire   = (phase_r == PH_RD) && q_valid;
  assign wr_fire   = (phase_r == PH_WR) && out_free;
  assign q_pop     = rd_fire;

  always_comb begin
    sid_h    = q_item.sid[SID_W-1:0];
    c_rd     = cur_r[sid_h];
    cidx_rd  = cur_idx_r[sid_h];
    behind   = c_rd < rp_r;
    eff      = behind ? rp_r : c_rd;
    eff_idx  = behind ? rp_idx_r : cidx_rd;
    lead     = behind ? '0 : c_rd - rp_r;
    mix_go   = (q_item.cmd == CMD_SUBMIT) && cfg.mixer_enable && (lead != RING_LEN);
    drain_go = (q_item.cmd == CMD_DRAIN) && cfg.mixer_enable && cfg.sink_present
               && (hw_r != rp_r);
    eff_inc  = eff + 32'd1;
    raise_hw = (eff >= hw_r) && (eff != '1);
    rd_addr  = (q_item.cmd == CMD_DRAIN) ? rp_idx_r : eff_idx;
  end

  always_comb begin
    mixed.l   = acc_add(rdata_r.l, left_r);
    mixed.r   = acc_add(rdata_r.r, right_r);
    mem_we    = clearing || (wr_fire && (op_mix_r || op_drain_r));
    mem_waddr = clearing ? clr_idx_r : addr_r;
    mem_wdata = (clearing || op_drain_r) ? slot_t'('0) : mixed;
    c_wr      = cur_r[sid_r];
    behind2   = c_wr < rp_r;
    dist2     = behind2 ? '0 : c_wr - rp_r;
    free2     = RING_LEN - dist2;
    space_now = cfg.mixer_enable ? sat_count(free2) : '0;
  end

  always_comb begin
    phase_nxt   = phase_r;
    clr_idx_nxt = clr_idx_r;
    unique case (phase_r)
      PH_CLR: begin
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == LAST_IDX) phase_nxt = PH_RD;
      end
      PH_RD: begin
        if (q_valid) phase_nxt = PH_WR;
      end
      PH_WR: begin
        if (out_free) phase_nxt = PH_RD;
      end
      default: phase_nxt = PH_CLR;
    endcase
    out_valid_nxt = wr_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CLR;
      clr_idx_r   <= '0;
      rp_r        <= '0;
      rp_idx_r    <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < STREAM_COUNT; i++) begin
        cur_r[i]     <= '0;
        cur_idx_r[i] <= '0;
      end
    end else begin
      phase_r     <= phase_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (rd_fire && mix_go) begin
        cur_r[sid_h]     <= eff_inc;
        cur_idx_r[sid_h] <= next_idx(eff, eff_idx);
        if (raise_hw) hw_r <= eff_inc;
      end
      if (rd_fire && drain_go) begin
        rp_r     <= rp_r + 32'd1;
        rp_idx_r <= next_idx(rp_r, rp_idx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) begin
      op_mix_r   <= mix_go;
      op_drain_r <= drain_go;
      cmd_r      <= q_item.cmd;
      last_r     <= q_item.last;
      sid_r      <= sid_h;
      addr_r     <= rd_addr;
      left_r     <= q_item.left;
      right_r    <= q_item.right;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[mem_waddr] <= mem_wdata;
    if (rd_fire) rdata_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      oleft_r  <= op_drain_r ? clamp16(rdata_r.l) : '0;
      oright_r <= op_drain_r ? clamp16(rdata_r.r) : '0;
      ofv_r    <= op_drain_r;
      oacc_r   <= op_mix_r;
      ospace_r <= space_now;
      obuf_r   <= sat_count(hw_r - rp_r);
      oeos_r   <= (cmd_r == CMD_SUBMIT) ? last_r : 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left        = oleft_r;
  assign out_right       = oright_r;
  assign out_frame_valid = ofv_r;
  assign out_accepted    = oacc_r;
  assign out_space       = ospace_r;
  assign out_buffered    = obuf_r;
  assign out_eos         = oeos_r;

  a_op_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WR) |-> !(op_mix_r && op_drain_r))
    else $error("mix and drain flagged on one item");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CLR) |-> (!out_valid_r && !q_pop))
    else $error("activity during ring clear");

  a_rp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_fire && drain_go) |=> (rp_r == $past(rp_r) + 32'd1))
    else $error("read position did not advance by one");

  a_wr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WR && !out_free) |=> (phase_r == PH_WR && $stable(addr_r)))
    else $error("write phase left while result register full");

endmodule

### src/multi_stream_ring_audio_mixer.sv
// Top level of the multi-stream stereo mixing ring: config registers,
// front queue (msam_front) and engine (msam_back). Uses msam_pkg.
//
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_ready   cmd, stream id, samples, last
//  out_     output     out_valid/out_ready frame, flags, space, buffered
//  cfg_     input      cfg_we              cfg_index, cfg_data
//
// Each item passes through the engine as a ring read, then a ring write-back.
// After reset the ring is zeroed, with in_ready low.
// A two-entry queue sits between front and engine; the result register lets
// the next item be read while a result waits. A stalled output holds the
// engine in its write phase.
module multi_stream_ring_audio_mixer
  import msam_pkg::*;
#(
  parameter int RING_FRAMES  = RING_FRAMES_DEF,
  parameter int STREAM_COUNT = STREAM_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [3:0]         in_stream_id,
  input  logic signed [15:0] in_left_sample,
  input  logic signed [15:0] in_right_sample,
  input  logic               in_last_of_submit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_out_left,
  output logic signed [15:0] out_out_right,
  output logic               out_out_valid,
  output logic               out_accepted,
  output logic [14:0]        out_stream_space,
  output logic [14:0]        out_buffered_frames,
  output logic               out_end_of_submit
);

  localparam logic [0:0] CFG_MIXER_ENABLE = 1'b0;
  localparam logic [0:0] CFG_SINK_PRESENT = 1'b1;

  cfg_t  cfg_r, cfg_nxt;
  logic  clearing;
  logic  q_valid, q_pop;
  item_t q_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIXER_ENABLE: cfg_nxt.mixer_enable = cfg_data;
        CFG_SINK_PRESENT: cfg_nxt.sink_present = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mixer_enable: 1'b1, sink_present: 1'b1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  msam_front #(
    .STREAM_COUNT(STREAM_COUNT)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .clearing         (clearing),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_stream_id     (in_stream_id),
    .in_left_sample   (in_left_sample),
    .in_right_sample  (in_right_sample),
    .in_last_of_submit(in_last_of_submit),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  msam_back #(
    .RING_FRAMES (RING_FRAMES),
    .STREAM_COUNT(STREAM_COUNT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_left       (out_out_left),
    .out_right      (out_out_right),
    .out_frame_valid(out_out_valid),
    .out_accepted   (out_accepted),
    .out_space      (out_stream_space),
    .out_buffered   (out_buffered_frames),
    .out_eos        (out_end_of_submit)
  );

endmodule

### sim/msam_checker.sv
// Register index names and the result checker of the stereo mixing ring.
// Watches the in_/out_/cfg_ ports, keeps its own copy of ring, cursors and
// registers, and compares every result beat. Depends on msam_pkg.
package msam_tb_pkg;

  typedef enum logic [0:0] {
    REG_MIXER_ENABLE = 1'b0,
    REG_SINK_PRESENT = 1'b1
  } cfg_reg_e;

endpackage

module msam_mix_checker
  import msam_pkg::*;
  import msam_tb_pkg::*;
#(
  parameter int RING_FRAMES  = RING_FRAMES_DEF,
  parameter int STREAM_COUNT = STREAM_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic               cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_cmd,
  input  logic [3:0]         in_stream_id,
  input  logic signed [15:0] in_left_sample,
  input  logic signed [15:0] in_right_sample,
  input  logic               in_last_of_submit,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_out_left,
  input  logic signed [15:0] out_out_right,
  input  logic               out_out_valid,
  input  logic               out_accepted,
  input  logic [14:0]        out_stream_space,
  input  logic [14:0]        out_buffered_frames,
  input  logic               out_end_of_submit,
  output int                 fail_count,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               frame_valid;
    logic               accepted;
    logic [14:0]        space;
    logic [14:0]        buffered;
    logic               eos;
  } mix_result_t;

  localparam logic [31:0] RING32 = RING_FRAMES;

  logic signed [18:0] acc_l [RING_FRAMES];
  logic signed [18:0] acc_r [RING_FRAMES];
  logic [31:0]        cursor [STREAM_COUNT];
  logic [31:0]        rd_pos;
  logic [31:0]        high_water;
  logic               mix_en;
  logic               sink_on;

  mix_result_t        frame_q [$];
  int                 mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic signed [18:0] acc_sat(input int sum);
    if (sum > int'(ACC_MAX)) return ACC_MAX;
    if (sum < int'(ACC_MIN)) return ACC_MIN;
    return 19'(sum);
  endfunction

  function automatic logic signed [15:0] clamp16(input logic signed [18:0] v);
    if (int'(v) > int'(SAMPLE_MAX)) return SAMPLE_MAX;
    if (int'(v) < int'(SAMPLE_MIN)) return SAMPLE_MIN;
    return 16'(v);
  endfunction

  function automatic logic [14:0] count_sat(input logic [31:0] v);
    return (v > 32'(COUNT_MAX)) ? COUNT_MAX : v[14:0];
  endfunction

  function automatic logic [31:0] eff_cursor(input int s);
    return (cursor[s] < rd_pos) ? rd_pos : cursor[s];
  endfunction

  function automatic mix_result_t mix_step(input item_t it);
    mix_result_t res;
    int          s;
    int          k;
    logic [31:0] wp;
    logic [31:0] avail;
    res = '0;
    s = (int'(it.sid) >= STREAM_COUNT) ? 0 : int'(it.sid);
    if (it.cmd == CMD_SUBMIT) begin
      res.eos = it.last;
      if (mix_en) begin
        wp = eff_cursor(s);
        avail = RING32 - (wp - rd_pos);
        if (avail != 0) begin
          k = int'(wp % RING32);
          acc_l[k] = acc_sat(int'(acc_l[k]) + int'(it.left));
          acc_r[k] = acc_sat(int'(acc_r[k]) + int'(it.right));
          wp = wp + 32'd1;
          cursor[s] = wp;
          if (wp > high_water) high_water = wp;
          res.accepted = 1'b1;
        end
      end
    end else if (mix_en && sink_on && high_water != rd_pos) begin
      k = int'(rd_pos % RING32);
      res.left = clamp16(acc_l[k]);
      res.right = clamp16(acc_r[k]);
      acc_l[k] = '0;
      acc_r[k] = '0;
      rd_pos = rd_pos + 32'd1;
      res.frame_valid = 1'b1;
    end
    res.space = mix_en ? count_sat(RING32 - (eff_cursor(s) - rd_pos)) : '0;
    res.buffered = count_sat(high_water - rd_pos);
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    item_t       beat;
    mix_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < RING_FRAMES; i++) begin
        acc_l[i] = '0;
        acc_r[i] = '0;
      end
      for (int i = 0; i < STREAM_COUNT; i++) cursor[i] = '0;
      rd_pos = '0;
      high_water = '0;
      mix_en = 1'b1;
      sink_on = 1'b1;
      frame_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (frame_q.size() == 0) begin
          $error("result beat with no prediction pending");
          mismatches++;
        end else begin
          want = frame_q.pop_front();
          check_field("out_left", int'($signed(want.left)), int'(out_out_left));
          check_field("out_right", int'($signed(want.right)), int'(out_out_right));
          check_field("out_valid", int'(want.frame_valid), int'(out_out_valid));
          check_field("accepted", int'(want.accepted), int'(out_accepted));
          check_field("stream_space", int'(want.space), int'(out_stream_space));
          check_field("buffered_frames", int'(want.buffered), int'(out_buffered_frames));
          check_field("end_of_submit", int'(want.eos), int'(out_end_of_submit));
        end
      end
      if (in_valid && in_ready) begin
        beat.cmd   = in_cmd;
        beat.sid   = in_stream_id;
        beat.left  = in_left_sample;
        beat.right = in_right_sample;
        beat.last  = in_last_of_submit;
        frame_q.push_back(mix_step(beat));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MIXER_ENABLE: mix_en = cfg_data;
          REG_SINK_PRESENT: sink_on = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= frame_q.size();
  end

endmodule

### sim/multi_stream_ring_audio_mixer_tb.sv
// Stimulus and verdict for the multi-stream stereo mixing ring.
// Drives beats and register writes; msam_mix_checker predicts and compares.
// Depends on msam_pkg, msam_tb_pkg and the block under test.
module multi_stream_ring_audio_mixer_tb;
  import msam_pkg::*;
  import msam_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_FRAMES  = RING_FRAMES_DEF;
  localparam int STREAM_COUNT = STREAM_COUNT_DEF;
  localparam int IDLE_LIMIT   = 4 * (RING_FRAMES + 64);

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = '0;
  logic               cfg_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_cmd = CMD_SUBMIT;
  logic [3:0]         in_stream_id = '0;
  logic signed [15:0] in_left_sample = '0;
  logic signed [15:0] in_right_sample = '0;
  logic               in_last_of_submit = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_out_left;
  logic signed [15:0] out_out_right;
  logic               out_out_valid;
  logic               out_accepted;
  logic [14:0]        out_stream_space;
  logic [14:0]        out_buffered_frames;
  logic               out_end_of_submit;

  int fail_count;
  int outstanding;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_run = 0;
  int stall_pct = 0;
  int pattern_age = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multi_stream_ring_audio_mixer #(
    .RING_FRAMES  (RING_FRAMES),
    .STREAM_COUNT (STREAM_COUNT)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_stream_id        (in_stream_id),
    .in_left_sample      (in_left_sample),
    .in_right_sample     (in_right_sample),
    .in_last_of_submit   (in_last_of_submit),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_out_left        (out_out_left),
    .out_out_right       (out_out_right),
    .out_out_valid       (out_out_valid),
    .out_accepted        (out_accepted),
    .out_stream_space    (out_stream_space),
    .out_buffered_frames (out_buffered_frames),
    .out_end_of_submit   (out_end_of_submit)
  );

  msam_mix_checker #(
    .RING_FRAMES  (RING_FRAMES),
    .STREAM_COUNT (STREAM_COUNT)
  ) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_stream_id        (in_stream_id),
    .in_left_sample      (in_left_sample),
    .in_right_sample     (in_right_sample),
    .in_last_of_submit   (in_last_of_submit),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_out_left        (out_out_left),
    .out_out_right       (out_out_right),
    .out_out_valid       (out_out_valid),
    .out_accepted        (out_accepted),
    .out_stream_space    (out_stream_space),
    .out_buffered_frames (out_buffered_frames),
    .out_end_of_submit   (out_end_of_submit),
    .fail_count          (fail_count),
    .outstanding         (outstanding)
  );

  // receiver: stall density is redrawn whenever the pattern age runs out
  always @(posedge clk) begin
    if (stall_run != 0) begin
      out_ready <= 1'b0;
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_run <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 10;
        2: stall_pct <= 40;
        default: stall_pct <= 80;
      endcase
      pattern_age <= $urandom_range(50, 400);
    end else begin
      pattern_age <= pattern_age - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL multi_stream_ring_audio_mixer");
      $finish;
    end
  end

  function automatic item_t mk(input logic cmd, input int sid, input int l, input int r,
                               input logic last);
    item_t it;
    it.cmd   = cmd;
    it.sid   = 4'(sid);
    it.left  = 16'(l);
    it.right = 16'(r);
    it.last  = last;
    return it;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 5))
      0: return 32767;
      1: return -32768;
      2: return int'($urandom_range(0, 64)) - 32;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic item_t rand_item(input int submit_pct);
    int sid;
    sid = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 7);
    return mk(($urandom_range(0, 99) < submit_pct) ? CMD_SUBMIT : CMD_DRAIN, sid,
              rand_sample(), rand_sample(), 1'($urandom));
  endfunction

  task automatic push_beat(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_cmd            <= it.cmd;
    in_stream_id      <= it.sid;
    in_left_sample    <= it.left;
    in_right_sample   <= it.right;
    in_last_of_submit <= it.last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic reconfigure(input logic en, input logic sink);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIXER_ENABLE;
    cfg_data  <= en;
    @(posedge clk);
    cfg_index <= REG_SINK_PRESENT;
    cfg_data  <= sink;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input logic en, input logic sink, input int n, input int pct);
    reconfigure(en, sink);
    repeat (n) push_beat(rand_item(pct));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    reconfigure(1'b1, 1'b1);

    // all streams pile extremes into one slot, then clamp on drain
    push_beat(mk(CMD_DRAIN, 9, 0, 0, 1'b1));
    push_beat(mk(CMD_SUBMIT, 8, 32767, -32768, 1'b0));
    for (int s = 1; s < STREAM_COUNT; s++) begin
      push_beat(mk(CMD_SUBMIT, s, 32767, -32768, 1'(s == STREAM_COUNT - 1)));
    end
    push_beat(mk(CMD_SUBMIT, 15, -32768, 32767, 1'b1));
    push_beat(mk(CMD_DRAIN, 0, 0, 0, 1'b0));
    push_beat(mk(CMD_DRAIN, 7, 0, 0, 1'b0));
    push_beat(mk(CMD_DRAIN, 3, 0, 0, 1'b0));
    // stream 3 now lags the read position
    push_beat(mk(CMD_SUBMIT, 3, 0, -1, 1'b1));
    push_beat(mk(CMD_DRAIN, 12, 0, 0, 1'b0));

    reconfigure(1'b1, 1'b0);
    push_beat(mk(CMD_SUBMIT, 4, 1, 1, 1'b1));
    push_beat(mk(CMD_DRAIN, 4, 0, 0, 1'b0));
    reconfigure(1'b0, 1'b0);
    push_beat(mk(CMD_SUBMIT, 6, 5, 5, 1'b1));
    push_beat(mk(CMD_DRAIN, 6, 0, 0, 1'b0));
    reconfigure(1'b0, 1'b1);
    push_beat(mk(CMD_SUBMIT, 14, -5, -5, 1'b0));
    push_beat(mk(CMD_DRAIN, 2, 0, 0, 1'b1));
    reconfigure(1'b1, 1'b1);
    push_beat(mk(CMD_DRAIN, 4, 0, 0, 1'b0));
    push_beat(mk(CMD_DRAIN, 4, 0, 0, 1'b0));

    // one stream runs well ahead, lagging streams catch up, then the ring drains dry
    for (int i = 0; i < 40; i++) begin
      push_beat(mk(CMD_SUBMIT, 5, rand_sample(), rand_sample(), 1'($urandom)));
    end
    for (int i = 0; i < 4; i++) begin
      push_beat(mk(CMD_SUBMIT, (i < 2) ? 2 : 13, rand_sample(), rand_sample(), 1'b0));
    end
    for (int i = 0; i < 48; i++) begin
      push_beat(mk(CMD_DRAIN, $urandom_range(0, 15), 0, 0, 1'($urandom)));
    end

    run_random(1'b1, 1'b1, 180, 60);
    run_random(1'b1, 1'b0, 50, 50);
    run_random(1'b1, 1'b1, 180, 45);
    run_random(1'b0, 1'b1, 40, 50);
    run_random(1'b1, 1'b1, 160, 55);
    run_random(1'b0, 1'b0, 35, 50);
    run_random(1'b1, 1'b1, 90, 40);

    settle();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS multi_stream_ring_audio_mixer");
    end else begin
      $display("FAIL multi_stream_ring_audio_mixer");
    end
    $finish;
  end

endmodule
